>>> rtl/core/des_pkg.sv
// DES package: permutation tables, S-boxes and helper functions.
// Used by des_round_cell, des_block_cipher and des_result_checker; no dependencies.
`default_nettype none
package des_pkg;

   localparam int NumRounds = 16;

   typedef logic [5:0] pos_type;

   typedef struct packed {
      logic        valid;
      logic        decrypt;
      logic [27:0] c_half;
      logic [27:0] d_half;
      logic [31:0] left;
      logic [31:0] right;
   } stage_type;

   localparam pos_type TabIp [64] = '{
      57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7,
      56,48,40,32,24,16,8,0, 58,50,42,34,26,18,10,2,
      60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6};
   localparam pos_type TabFp [64] = '{
      39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28,
      35,3,43,11,51,19,59,27, 34,2,42,10,50,18,58,26,
      33,1,41,9,49,17,57,25, 32,0,40,8,48,16,56,24};
   localparam pos_type TabE [48] = '{
      31,0,1,2,3,4, 3,4,5,6,7,8, 7,8,9,10,11,12, 11,12,13,14,15,16,
      15,16,17,18,19,20, 19,20,21,22,23,24, 23,24,25,26,27,28, 27,28,29,30,31,0};
   localparam pos_type TabP [32] = '{
      15,6,19,20,28,11,27,16, 0,14,22,25,4,17,30,9,
      1,7,23,13,31,26,2,8, 18,12,29,5,21,10,3,24};
   localparam pos_type TabPc1 [56] = '{
      56,48,40,32,24,16,8, 0,57,49,41,33,25,17,
      9,1,58,50,42,34,26, 18,10,2,59,51,43,35,
      62,54,46,38,30,22,14, 6,61,53,45,37,29,21,
      13,5,60,52,44,36,28, 20,12,4,27,19,11,3};
   localparam pos_type TabPc2 [48] = '{
      13,16,10,23,0,4, 2,27,14,5,20,9, 22,18,11,3,25,7, 15,6,26,19,12,1,
      40,51,30,36,46,54, 29,39,50,44,32,47, 43,48,38,55,33,52, 45,41,49,35,28,31};
   localparam logic [15:0] ShiftTwo = 16'b0111_1110_1111_1100; // bit i: round i shifts by 2

   localparam logic [3:0] TabS [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // Positions are counted from the MSB (FIPS bit 1 = index 0).
   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[63-TabIp[i]];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[63-TabFp[i]];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[63-TabPc1[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[55-TabPc2[i]];
      return r;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] rv, input logic [47:0] k);
      logic [47:0] e;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) e[47-i] = rv[31-TabE[i]];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         six = e[47-6*i -: 6];
         s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[31-TabP[i]];
      return p;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/des_round_cell.sv
// DES round cell: one Feistel round plus its key-schedule step, registered.
// Depends on des_pkg.
`default_nettype none
module des_round_cell #(
   parameter int Round = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  des_pkg::stage_type     stage_in,
   output des_pkg::stage_type     stage_out
);
   import des_pkg::*;

   localparam logic TwoEnc = ShiftTwo[Round];
   // Decrypt walks the schedule backwards: rotate right, no rotate before round 0.
   localparam logic TwoDec = (Round == 0) ? 1'b0
                                          : ShiftTwo[(NumRounds - Round) % NumRounds];
   localparam logic OneDec = (Round != 0) && !TwoDec;

   stage_type   stage_ff, stage_in_w;
   logic [27:0] c_w, d_w;
   logic [47:0] key_w;

   always_comb begin
      if (!stage_in.decrypt) begin
         c_w = TwoEnc ? {stage_in.c_half[25:0], stage_in.c_half[27:26]}
                      : {stage_in.c_half[26:0], stage_in.c_half[27]};
         d_w = TwoEnc ? {stage_in.d_half[25:0], stage_in.d_half[27:26]}
                      : {stage_in.d_half[26:0], stage_in.d_half[27]};
      end else if (TwoDec) begin
         c_w = {stage_in.c_half[1:0], stage_in.c_half[27:2]};
         d_w = {stage_in.d_half[1:0], stage_in.d_half[27:2]};
      end else if (OneDec) begin
         c_w = {stage_in.c_half[0], stage_in.c_half[27:1]};
         d_w = {stage_in.d_half[0], stage_in.d_half[27:1]};
      end else begin
         c_w = stage_in.c_half;
         d_w = stage_in.d_half;
      end
      key_w = perm_pc2({c_w, d_w});
      stage_in_w         = stage_in;
      stage_in_w.c_half  = c_w;
      stage_in_w.d_half  = d_w;
      stage_in_w.left    = stage_in.right;
      stage_in_w.right   = stage_in.left ^ feistel(stage_in.right, key_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (advance) begin
         stage_ff.decrypt <= stage_in_w.decrypt;
         stage_ff.c_half  <= stage_in_w.c_half;
         stage_ff.d_half  <= stage_in_w.d_half;
         stage_ff.left    <= stage_in_w.left;
         stage_ff.right   <= stage_in_w.right;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

>>> rtl/core/des_block_cipher.sv
// DES block cipher top level: input mapping, sixteen round cells, output stage.
// Depends on des_pkg and des_round_cell.
//
// Usage:
//   req_* channel: tdata = data_block[63:0]; tuser = req_type (0 encrypt, 1 decrypt).
//   rsp_* channel: tdata = result_block[63:0].
//   csr_*: key register, written whenever csr_wr_en is high; the user must write it only while idle (not enforced).
//   Each transaction enters a chain of 16 round cells; one cell per Feistel round
//   carries the block halves and the rotating C/D key halves to its neighbor.
//   A result passes through the 16 round cells and then the output register
//   holding the final permutation before rsp_tvalid.
//   Throughput: one transaction per cycle while the receiver takes results.
//   The whole chain advances together; when rsp_tvalid is high and rsp_tready
//   low the chain freezes and req_tready drops, unless the output slot is free
//   or being emptied. Empty cells are not squeezed out: a stalled output
//   freezes every cell, so nothing is accepted until the receiver takes the
//   waiting result. Up to 17 transactions are held in the cells and output.
//   Reset (synchronous, active high) clears all valid bits and the key to zero.
`default_nettype none
module des_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // data_block[63:0]
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // result_block[63:0]
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data
);
   import des_pkg::*;

   logic [63:0] key_ff;
   stage_type   chain_w [NumRounds+1];
   stage_type   head_w;
   logic        out_valid_ff;
   logic [63:0] out_data_ff;
   logic        advance_w;
   logic [63:0] ip_w;
   logic [55:0] cd_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   // Chain moves whenever the output register is empty or being taken.
   assign advance_w  = !out_valid_ff || rsp_tready;
   assign req_tready = advance_w;

   always_comb begin
      ip_w = perm_ip(req_tdata);
      cd_w = perm_pc1(key_ff);
      head_w.valid   = req_tvalid;
      head_w.decrypt = req_tuser;
      // Decrypt starts from the fully rotated schedule, which equals the PC-1 halves.
      head_w.c_half  = cd_w[55:28];
      head_w.d_half  = cd_w[27:0];
      head_w.left    = ip_w[63:32];
      head_w.right   = ip_w[31:0];
   end

   assign chain_w[0] = head_w;

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      des_round_cell #(.Round(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance_w),
         .stage_in  (chain_w[g]),
         .stage_out (chain_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance_w) begin
         out_valid_ff <= chain_w[NumRounds].valid;
      end
      if (advance_w) begin
         out_data_ff <= perm_fp({chain_w[NumRounds].right, chain_w[NumRounds].left});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!out_valid_ff || rsp_tready))
      else $error("ready disagrees with output slot");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance_w && chain_w[NumRounds].valid |=> out_valid_ff)
      else $error("result lost at chain end");
endmodule
`default_nettype wire

>>> dv/des_result_checker.sv
// Scoreboard for des_block_cipher: watches the request, response and key channels,
// predicts each result with its own DES model and compares. Depends on des_pkg.
`default_nettype none
module des_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data,
   output int               error_count,
   output int               pending_count
);
   import des_pkg::*;

   localparam logic DirEncrypt = 1'b0;

   // tables in FIPS numbering (1 = MSB)
   localparam byte IpMap [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam byte FpMap [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam byte EMap [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam byte PMap [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam byte Pc1Map [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam byte Pc2Map [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam byte RotAmt [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   logic [63:0] key_reg;
   logic [63:0] expected_blocks[$];

   // generic MSB-first bit select
   function automatic logic [63:0] pick(logic [63:0] v, int in_w, int out_w, const ref byte m[]);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < out_w; i++) r = (r << 1) | ((v >> (in_w - m[i])) & 64'd1);
      return r;
   endfunction

   function automatic logic [63:0] des_compute(logic [63:0] key, logic [63:0] blk, logic dir);
      byte m[];
      logic [47:0] sub[16];
      logic [27:0] c, d;
      logic [55:0] cd;
      logic [31:0] l, r, t, sb, fo;
      logic [47:0] e;
      logic [5:0]  six;
      logic [63:0] v;
      m = Pc1Map; cd = pick(key, 64, 56, m);
      c = cd[55:28]; d = cd[27:0];
      m = Pc2Map;
      for (int i = 0; i < 16; i++) begin
         c = (c << RotAmt[i]) | (c >> (28 - RotAmt[i]));
         d = (d << RotAmt[i]) | (d >> (28 - RotAmt[i]));
         sub[i] = pick({c, d}, 56, 48, m);
      end
      m = IpMap; v = pick(blk, 64, 64, m);
      l = v[63:32]; r = v[31:0];
      for (int i = 0; i < 16; i++) begin
         m = EMap;
         e = pick(r, 32, 48, m) ^ ((dir == DirEncrypt) ? sub[i] : sub[15-i]);
         sb = '0;
         for (int j = 0; j < 8; j++) begin
            six = e[47-6*j -: 6];
            sb = (sb << 4) | TabS[j][{six[5], six[0], six[4:1]}];
         end
         m = PMap; fo = pick(sb, 32, 32, m);
         t = r; r = l ^ fo; l = t;
      end
      m = FpMap;
      return pick({r, l}, 64, 64, m);
   endfunction

   assign pending_count = expected_blocks.size();

   always @(posedge clock) begin
      if (reset) begin
         key_reg <= '0;
         expected_blocks.delete();
      end else begin
         if (csr_wr_en) key_reg <= csr_wr_data;
         if (req_tvalid && req_tready)
            expected_blocks = {expected_blocks, des_compute(key_reg, req_tdata, req_tuser)};
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               $error("unexpected transaction: result_block=%h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               if (rsp_tdata !== expected_blocks[0]) begin
                  $error("result_block mismatch: expected %h actual %h",
                         expected_blocks[0], rsp_tdata);
                  error_count <= error_count + 1;
               end
               void'(expected_blocks.pop_front());
            end
         end
      end
   end

   initial error_count = 0;
endmodule
`default_nettype wire

>>> dv/tb.sv
// Top of the des_block_cipher testbench: clock, reset, stimulus and verdict.
// Depends on des_pkg, des_block_cipher and des_result_checker.
`default_nettype none
module tb;
   localparam logic TypeEncrypt = 1'b0;
   localparam logic TypeDecrypt = 1'b1;
   localparam int   DrainCycles = 40;      // settling margin after the last result
   localparam int   CycleLimit  = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en = 0;
   logic [63:0] csr_wr_data = '0;
   int          error_count, pending_count;
   int          cycle_count = 0;
   int          item_count = 0;
   bit          long_hold = 0;   // request from stimulus to freeze the receiver
   bit          hold_done = 0;

   always #10 clock = ~clock;

   des_block_cipher dut (.*);

   des_result_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stall patterns, plus one long hold to fill the chain
   initial begin
      int mode, len;
      @(negedge reset);
      forever begin
         if (long_hold && !hold_done) begin
            rsp_tready <= 0;
            repeat (60) @(posedge clock);
            hold_done = 1;
         end
         mode = $urandom_range(0, 2);
         len = $urandom_range(1, 30);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   // one transaction; valid stays high between back-to-back items
   task automatic send_block(logic kind, logic [63:0] blk);
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= blk;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // wait until every expected result has come back, then let the chain settle
   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_key(logic [63:0] k);
      csr_wr_en   <= 1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            send_block($urandom_range(0, 1) ? TypeDecrypt : TypeEncrypt, rand64());
            n--;
         end
         if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [63:0] keys[6];
      keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1334_5779_9BBC_DFF1,
               64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE, 64'h0};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset key, then classic key with known vector and extremes
      send_block(TypeEncrypt, 64'h0);
      send_block(TypeDecrypt, 64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      load_key(64'h1334_5779_9BBC_DFF1);
      send_block(TypeEncrypt, 64'h0123_4567_89AB_CDEF);   // textbook vector
      send_block(TypeDecrypt, 64'h85E8_1354_0F0A_B405);
      send_block(TypeEncrypt, 64'h0);
      send_block(TypeEncrypt, 64'hFFFF_FFFF_FFFF_FFFF);
      send_block(TypeDecrypt, 64'h0);
      send_block(TypeDecrypt, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int b = 0; b < 64; b += 8) send_block(b[3] ? TypeDecrypt : TypeEncrypt, 64'h1 << b);
      drain();
      // key parity bits flipped: must give the same results
      load_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
      send_block(TypeEncrypt, 64'h0123_4567_89AB_CDEF);
      send_block(TypeDecrypt, 64'h85E8_1354_0F0A_B405);

      // sender keeps offering while the receiver holds off
      long_hold = 1;
      while (!hold_done) send_block(TypeEncrypt, rand64());
      drain();

      // random phases across keys, extremes included
      foreach (keys[i]) begin
         load_key(i == 5 ? rand64() : keys[i]);
         random_phase(160);
         drain();
      end

      $display("Checked %0d DES transactions over weak, all-ones and random keys,",
               item_count);
      $display("both directions, with sender gaps and receiver stalls.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> des_block_cipher.f
rtl/core/des_pkg.sv
rtl/core/des_round_cell.sv
rtl/core/des_block_cipher.sv
dv/des_result_checker.sv
dv/tb.sv
